FILE: rtl/core/nkia_pkg.sv
// Shared types and constants for the nearest key index assigner.
package nkia_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned GAP_W = 17;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic              eval;
    logic              load_we;
    logic              find;
    logic              assign_we;
    logic [KEY_W-1:0]  v;
    logic [IDX_W-1:0]  new_idx;
  } cell_cmd_t;

  // What one cell shows to its neighbors and to the sequencer.
  typedef struct packed {
    logic              occ;
    logic              gt;
    logic              eq;
    logic              win;
    logic [GAP_W-1:0]  gap;
    logic [KEY_W-1:0]  key;
    logic              aval;
    logic [IDX_W-1:0]  aidx;
  } cell_state_t;

endpackage

FILE: rtl/core/nkia_in_if.sv
// Input channel carrying load and query items.
interface nkia_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [nkia_pkg::KEY_W-1:0] hu_value;

  modport source (output valid, output op, output hu_value, input ready);
  modport sink   (input valid, input op, input hu_value, output ready);
endinterface

FILE: rtl/core/nkia_out_if.sv
// Output channel carrying one result per item.
interface nkia_out_if;
  logic                              valid;
  logic                              ready;
  logic        [nkia_pkg::IDX_W-1:0] material_index;
  logic signed [nkia_pkg::KEY_W-1:0] nearest_key;
  logic                              newly_assigned;
  logic        [1:0]                 status;

  modport source (output valid, output material_index, output nearest_key,
                  output newly_assigned, output status, input ready);
  modport sink   (input valid, input material_index, input nearest_key,
                  input newly_assigned, input status, output ready);
endinterface

FILE: rtl/core/nkia_cell.sv
// One table slot: key, assigned index and the local compare logic.
module nkia_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nkia_pkg::cell_cmd_t   cmd_i,
  input  nkia_pkg::cell_state_t left_i,
  input  nkia_pkg::cell_state_t right_i,
  output nkia_pkg::cell_state_t state_o
);
  import nkia_pkg::*;

  logic              occ_q, aval_q;
  logic              gt_q, eq_q, win_q;
  logic [GAP_W-1:0]  gap_q;
  logic [KEY_W-1:0]  key_q;
  logic [IDX_W-1:0]  aidx_q;

  logic [GAP_W-1:0]  diff;
  logic [GAP_W-1:0]  abs_diff;
  logic              open_slot;
  logic              left_open;
  logic              take_left;
  logic              take_v;
  logic              claim;

  assign diff      = {cmd_i.v[KEY_W-1], cmd_i.v} - {key_q[KEY_W-1], key_q};
  assign abs_diff  = diff[GAP_W-1] ? (~diff + {{(GAP_W-1){1'b0}}, 1'b1}) : diff;
  assign open_slot = gt_q | ~occ_q;
  assign left_open = left_i.gt | ~left_i.occ;
  assign take_left = cmd_i.load_we & open_slot & left_open;
  assign take_v    = cmd_i.load_we & open_slot & ~left_open;
  assign claim     = cmd_i.assign_we & win_q & ~aval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      aval_q <= 1'b0;
    end else begin
      if (take_left) begin
        occ_q  <= left_i.occ;
        aval_q <= left_i.aval;
      end else if (take_v) begin
        occ_q  <= 1'b1;
        aval_q <= 1'b0;
      end else if (claim) begin
        aval_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      gt_q  <= occ_q & ($signed(key_q) > $signed(cmd_i.v));
      eq_q  <= occ_q & (key_q == cmd_i.v);
      gap_q <= abs_diff;
    end
    if (cmd_i.find) begin
      win_q <= occ_q & (left_i.gap > gap_q) & (~right_i.occ | (gap_q <= right_i.gap));
    end
    if (take_left) begin
      key_q  <= left_i.key;
      aidx_q <= left_i.aidx;
    end else if (take_v) begin
      key_q <= cmd_i.v;
    end else if (claim) begin
      aidx_q <= cmd_i.new_idx;
    end
  end

  assign state_o.occ  = occ_q;
  assign state_o.gt   = gt_q;
  assign state_o.eq   = eq_q;
  assign state_o.win  = win_q;
  assign state_o.gap  = gap_q;
  assign state_o.key  = key_q;
  assign state_o.aval = aval_q;
  assign state_o.aidx = aidx_q;

endmodule

FILE: rtl/core/nearest_key_index_assigner.sv
// Top level: sorted key table as a row of cells with a small sequencer.
//
// The table is a row of TABLE_DEPTH cells kept in ascending key order. For a
// load, the cells compare the key in parallel, then every cell above the
// insertion point takes its left neighbor's contents in a single shift. For a
// query, each cell forms its distance to the value, then finds locally whether
// it is nearer than both neighbors, and the single winning cell assigns the
// next index if it has none yet. One item is in flight at a time and the
// input is ready again once the result has moved into the output register,
// so the next item is not taken before then; a stalled output can hold a
// finished result in the sequencer and with it the next input transfer.
// The per-slot valid bits clear at reset, so no clearing pass is needed.
module nearest_key_index_assigner #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nkia_pkg::IDX_W-1:0]   cfg_wdata_i,
  nkia_in_if.sink                      in_i,
  nkia_out_if.source                   out_o
);
  import nkia_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_ASSIGN,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] key_count_q;
  logic [IDX_W-1:0] assigned_count_q;
  logic [IDX_W-1:0] base_index_q;
  logic             op_q;
  logic [KEY_W-1:0] v_q;

  logic [IDX_W-1:0] res_idx_q;
  logic [KEY_W-1:0] res_key_q;
  logic             res_new_q;
  logic [1:0]       res_status_q;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [KEY_W-1:0] out_key_q;
  logic             out_new_q;
  logic [1:0]       out_status_q;

  cell_cmd_t   cmd;
  cell_state_t cell_st  [TABLE_DEPTH];
  cell_state_t left_st  [TABLE_DEPTH];
  cell_state_t right_st [TABLE_DEPTH];

  logic             dup;
  logic             full;
  logic             sel_aval;
  logic [KEY_W-1:0] sel_key;
  logic [IDX_W-1:0] sel_aidx;
  logic [IDX_W-1:0] next_idx;
  logic             out_load;

  assign full     = (key_count_q == CNT_W'(TABLE_DEPTH));
  assign next_idx = base_index_q + assigned_count_q;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    cmd.eval      = (state_q == S_EVAL);
    cmd.load_we   = (state_q == S_DECIDE) && (op_q == OP_LOAD) && !dup && !full;
    cmd.find      = (state_q == S_DECIDE) && (op_q == OP_QUERY);
    cmd.assign_we = (state_q == S_ASSIGN);
    cmd.v         = v_q;
    cmd.new_idx   = next_idx;
  end

  // The first cell sees a left neighbor that is occupied, below the value
  // and infinitely far; the last cell sees an empty right neighbor.
  always_comb begin
    cell_state_t edge_left;
    cell_state_t edge_right;
    edge_left      = '0;
    edge_left.occ  = 1'b1;
    edge_left.gap  = '1;
    edge_right     = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      left_st[i]  = (i == 0) ? edge_left : cell_st[(i == 0) ? 0 : i - 1];
      right_st[i] = (i == TABLE_DEPTH - 1) ? edge_right
                                           : cell_st[(i == TABLE_DEPTH - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    nkia_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_st[g]),
      .right_i (right_st[g]),
      .state_o (cell_st[g])
    );
  end

  always_comb begin
    dup      = 1'b0;
    sel_aval = 1'b0;
    sel_key  = '0;
    sel_aidx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      dup      = dup | cell_st[i].eq;
      sel_aval = sel_aval | (cell_st[i].win & cell_st[i].aval);
      sel_key  = sel_key  | (cell_st[i].win ? cell_st[i].key  : '0);
      sel_aidx = sel_aidx | (cell_st[i].win ? cell_st[i].aidx : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      key_count_q      <= '0;
      assigned_count_q <= '0;
      base_index_q     <= '0;
      op_q             <= OP_LOAD;
      v_q              <= '0;
      res_idx_q        <= '0;
      res_key_q        <= '0;
      res_new_q        <= 1'b0;
      res_status_q     <= ST_OK;
      out_valid_q      <= 1'b0;
      out_idx_q        <= '0;
      out_key_q        <= '0;
      out_new_q        <= 1'b0;
      out_status_q     <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        base_index_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.op;
            v_q     <= in_i.hu_value;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          res_idx_q <= '0;
          res_key_q <= '0;
          res_new_q <= 1'b0;
          if (op_q == OP_LOAD) begin
            res_status_q <= (!dup && full) ? ST_FULL : ST_OK;
            if (!dup && !full) begin
              key_count_q <= key_count_q + CNT_W'(1);
            end
            state_q <= S_DONE;
          end else if (key_count_q == '0) begin
            res_status_q <= ST_EMPTY;
            state_q      <= S_DONE;
          end else begin
            res_status_q <= ST_OK;
            state_q      <= S_ASSIGN;
          end
        end
        S_ASSIGN: begin
          res_key_q <= sel_key;
          if (sel_aval) begin
            res_idx_q <= sel_aidx;
            res_new_q <= 1'b0;
          end else begin
            res_idx_q        <= next_idx;
            res_new_q        <= 1'b1;
            assigned_count_q <= assigned_count_q + IDX_W'(1);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_idx_q    <= res_idx_q;
            out_key_q    <= res_key_q;
            out_new_q    <= res_new_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.material_index = out_idx_q;
  assign out_o.nearest_key    = out_key_q;
  assign out_o.newly_assigned = out_new_q;
  assign out_o.status         = out_status_q;

endmodule
